>>> rtl/core/throughput_throttle_regulator_defines.svh
`ifndef THROUGHPUT_THROTTLE_REGULATOR_DEFINES_SVH
`define THROUGHPUT_THROTTLE_REGULATOR_DEFINES_SVH

// same-cycle implication, checked while out of reset
`define TTR_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("ttr: same-cycle check failed");

// next-cycle implication, checked while out of reset
`define TTR_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("ttr: next-cycle check failed");

`endif

>>> rtl/core/ttr_pkg.sv
`timescale 1ns / 1ps

package ttr_pkg;

    localparam int TTR_LANES     = 4;
    localparam int TTR_IDX_W     = (TTR_LANES > 1) ? $clog2(TTR_LANES) : 1;
    localparam int TTR_SAMPLE_W  = 32;
    localparam int TTR_SUM_W     = 48;
    localparam int TTR_TICK_W    = 12;
    localparam int TTR_RATE_W    = 40;
    localparam int TTR_CFG_IDX_W = 2;
    localparam int TTR_LHS_W     = TTR_SUM_W + 10;          // sum * 1000
    localparam int TTR_RHS_W     = TTR_RATE_W + TTR_TICK_W; // max_rate * ticks

    localparam logic [TTR_SUM_W-1:0]  TTR_SUM_MAX  = '1;
    localparam logic [TTR_TICK_W-1:0] TTR_TICK_MAX = '1;
    localparam logic [TTR_TICK_W-1:0] TTR_WIN_RST  = TTR_TICK_W'(1000);

    localparam logic [TTR_CFG_IDX_W-1:0] TTR_REG_MAX_RATE = 2'd0;
    localparam logic [TTR_CFG_IDX_W-1:0] TTR_REG_WIN_LEN  = 2'd1;

    typedef logic [TTR_SAMPLE_W-1:0] t_sample;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LANE,
        S_MUL,
        S_UPD,
        S_DONE
    } t_state;

    typedef struct packed {
        logic                 load;
        logic                 lane_en;
        logic [TTR_IDX_W-1:0] lane_idx;
        logic                 mul_en;
        logic                 upd_en;
        logic                 out_load;
    } t_ctrl;

endpackage

>>> rtl/core/throughput_throttle_regulator.sv
// An accepted transaction runs its lanes one per cycle through a shared add/saturate
// unit, then a multiply step, a compare/update step and an output load step; when
// max_rate is 0 the lanes and the multiply step are skipped. A new transaction is
// accepted only in the idle state, after the output load of the last one.
// A stalled output holds the next transaction back.
// Reset (synchronous, active low): last lane samples, window sum, tick count and throttle
// clear; max_rate resets to 0, window_length to 1000.
`timescale 1ns / 1ps

`include "throughput_throttle_regulator_defines.svh"

module throughput_throttle_regulator (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic [ttr_pkg::TTR_SAMPLE_W-1:0]     i_sample_0,
    input  logic [ttr_pkg::TTR_SAMPLE_W-1:0]     i_sample_1,
    input  logic [ttr_pkg::TTR_SAMPLE_W-1:0]     i_sample_2,
    input  logic [ttr_pkg::TTR_SAMPLE_W-1:0]     i_sample_3,
    input  logic                                 i_busy_0,
    input  logic                                 i_busy_1,
    input  logic                                 i_busy_2,
    input  logic                                 i_busy_3,
    input  logic                                 i_external_hold,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic                                 o_throttle,
    output logic [ttr_pkg::TTR_SUM_W-1:0]        o_window_total,
    output logic [ttr_pkg::TTR_TICK_W-1:0]       o_ticks_in_window,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [ttr_pkg::TTR_CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [ttr_pkg::TTR_RATE_W-1:0]       i_cfg_data
);
    import ttr_pkg::*;

    logic [TTR_RATE_W-1:0]   r_max_rate;
    logic [TTR_TICK_W-1:0]   r_window_length;

    logic                    r_out_valid;
    logic                    r_out_thr;
    logic [TTR_SUM_W-1:0]    r_out_sum;
    logic [TTR_TICK_W-1:0]   r_out_tick;

    t_ctrl                   w_ctrl;
    t_sample [TTR_LANES-1:0] w_sample;
    logic [TTR_LANES-1:0]    w_busy;
    logic                    w_out_free;
    logic                    w_thr;
    logic [TTR_SUM_W-1:0]    w_sum;
    logic [TTR_TICK_W-1:0]   w_tick;

    assign w_sample   = {i_sample_3, i_sample_2, i_sample_1, i_sample_0};
    assign w_busy     = {i_busy_3, i_busy_2, i_busy_1, i_busy_0};
    assign w_out_free = !r_out_valid || i_out_ready;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_rate      <= '0;
            r_window_length <= TTR_WIN_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                TTR_REG_MAX_RATE: r_max_rate      <= i_cfg_data;
                TTR_REG_WIN_LEN:  r_window_length <= i_cfg_data[TTR_TICK_W-1:0];
                default: ;
            endcase
        end
    end

    ttr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_enable   (r_max_rate != '0),
        .i_out_free (w_out_free),
        .o_in_ready (o_in_ready),
        .o_ctrl     (w_ctrl)
    );

    ttr_accum u_accum (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_ctrl          (w_ctrl),
        .i_sample        (w_sample),
        .i_busy          (w_busy),
        .i_hold          (i_external_hold),
        .i_max_rate      (r_max_rate),
        .i_window_length (r_window_length),
        .o_throttle      (w_thr),
        .o_sum           (w_sum),
        .o_tick          (w_tick)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_ctrl.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ctrl.out_load) begin
            r_out_thr  <= w_thr;
            r_out_sum  <= w_sum;
            r_out_tick <= w_tick;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_throttle        = r_out_thr;
    assign o_window_total    = r_out_sum;
    assign o_ticks_in_window = r_out_tick;

    `TTR_ASSERT_NEXT(a_busy_after_accept, i_in_valid && o_in_ready, !o_in_ready)
    `TTR_ASSERT_IMP(a_no_overwrite, w_ctrl.out_load, !r_out_valid || i_out_ready)
    `TTR_ASSERT_IMP(a_thr_not_at_window_start, o_out_valid && o_throttle, o_ticks_in_window != '0)

endmodule

>>> rtl/core/ttr_ctrl.sv
`timescale 1ns / 1ps

module ttr_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic           i_enable,
    input  logic           i_out_free,
    output logic           o_in_ready,
    output ttr_pkg::t_ctrl o_ctrl
);
    import ttr_pkg::*;

    t_state               r_state, n_state;
    logic [TTR_IDX_W-1:0] r_idx, n_idx;
    logic                 w_last_lane;

    assign w_last_lane = (r_idx == TTR_IDX_W'(TTR_LANES - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
        end
    end

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        case (r_state)
            S_IDLE: begin
                n_idx = '0;
                if (i_in_valid) begin
                    n_state = i_enable ? S_LANE : S_UPD;
                end
            end
            S_LANE: begin
                n_idx = r_idx + 1'b1;
                if (w_last_lane) begin
                    n_state = S_MUL;
                    n_idx   = '0;
                end
            end
            S_MUL:  n_state = S_UPD;
            S_UPD:  n_state = S_DONE;
            S_DONE: begin
                if (i_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready      = 1'b0;
        o_ctrl          = '0;
        o_ctrl.lane_idx = r_idx;
        case (r_state)
            S_IDLE: begin
                o_in_ready  = 1'b1;
                o_ctrl.load = i_in_valid;
            end
            S_LANE: o_ctrl.lane_en  = 1'b1;
            S_MUL:  o_ctrl.mul_en   = 1'b1;
            S_UPD:  o_ctrl.upd_en   = 1'b1;
            S_DONE: o_ctrl.out_load = i_out_free;
            default: o_in_ready     = 1'b0;
        endcase
    end

endmodule

>>> rtl/core/ttr_accum.sv
`timescale 1ns / 1ps

module ttr_accum (
    input  logic                                          i_clk,
    input  logic                                          i_rst_n,
    input  ttr_pkg::t_ctrl                                i_ctrl,
    input  ttr_pkg::t_sample [ttr_pkg::TTR_LANES-1:0]     i_sample,
    input  logic [ttr_pkg::TTR_LANES-1:0]                 i_busy,
    input  logic                                          i_hold,
    input  logic [ttr_pkg::TTR_RATE_W-1:0]                i_max_rate,
    input  logic [ttr_pkg::TTR_TICK_W-1:0]                i_window_length,
    output logic                                          o_throttle,
    output logic [ttr_pkg::TTR_SUM_W-1:0]                 o_sum,
    output logic [ttr_pkg::TTR_TICK_W-1:0]                o_tick
);
    import ttr_pkg::*;

    // captured transaction
    t_sample [TTR_LANES-1:0] r_smp;
    logic [TTR_LANES-1:0]    r_busy;
    logic                    r_hold;

    // regulator state
    t_sample [TTR_LANES-1:0] r_last;
    logic [TTR_SUM_W-1:0]    r_sum, n_sum;
    logic [TTR_TICK_W-1:0]   r_tick, n_tick;
    logic                    r_thr, n_thr;

    logic [TTR_LHS_W-1:0]    r_lhs;
    logic [TTR_RHS_W-1:0]    r_rhs;

    t_sample                 w_smp;
    t_sample                 w_delta;
    logic [TTR_SUM_W:0]      w_add;
    logic [TTR_SUM_W-1:0]    w_sat;
    logic [TTR_LHS_W-1:0]    w_sum_ext;
    logic                    w_enable;
    logic                    w_reached;
    logic                    w_win_end;

    assign w_enable  = (i_max_rate != '0);
    assign w_smp     = r_smp[i_ctrl.lane_idx];
    assign w_delta   = w_smp - r_last[i_ctrl.lane_idx];
    assign w_add     = {1'b0, r_sum} + (TTR_SUM_W + 1)'(w_delta);
    assign w_sat     = w_add[TTR_SUM_W] ? TTR_SUM_MAX : w_add[TTR_SUM_W-1:0];
    assign w_sum_ext = TTR_LHS_W'(r_sum);
    assign w_reached = (r_lhs >= TTR_LHS_W'(r_rhs));
    assign w_win_end = (r_tick > i_window_length) || (r_tick == TTR_TICK_MAX);

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_smp  <= i_sample;
            r_busy <= i_busy;
            r_hold <= i_hold;
        end
        if (i_ctrl.mul_en) begin
            // x1000 = x1024 - x16 - x8
            r_lhs <= (w_sum_ext << 10) - (w_sum_ext << 4) - (w_sum_ext << 3);
            r_rhs <= TTR_RHS_W'(i_max_rate) * TTR_RHS_W'(r_tick);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last <= '0;
        end else if (i_ctrl.lane_en && r_busy[i_ctrl.lane_idx]) begin
            r_last[i_ctrl.lane_idx] <= w_smp;
        end
    end

    always_comb begin
        n_sum  = r_sum;
        n_tick = r_tick;
        n_thr  = r_thr;
        if (i_ctrl.lane_en) begin
            if (r_busy[i_ctrl.lane_idx]) begin
                n_sum = w_sat;
            end else begin
                n_thr = 1'b0;
            end
        end
        if (i_ctrl.upd_en) begin
            if (w_enable && (r_tick != '0) && !r_hold) begin
                n_thr = w_reached;
            end
            if (r_hold) begin
                n_thr = 1'b0;
            end
            if (w_win_end) begin
                n_tick = '0;
                n_sum  = '0;
                n_thr  = 1'b0;
            end else begin
                n_tick = r_tick + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum  <= '0;
            r_tick <= '0;
            r_thr  <= 1'b0;
        end else begin
            r_sum  <= n_sum;
            r_tick <= n_tick;
            r_thr  <= n_thr;
        end
    end

    assign o_throttle = r_thr;
    assign o_sum      = r_sum;
    assign o_tick     = r_tick;

endmodule
